### rtl/rssc_pkg.sv
`timescale 1ns / 1ps
// rssc_pkg: shared types and codes of the run-length sprite scanline checker
// no dependencies; used by rssc_front, rssc_fifo, rssc_back and the core

package rssc_pkg;

  localparam int DS_W    = 15;   // data_size register
  localparam int SW_W    = 16;   // sprite_width register
  localparam int BPP_W   = 3;    // bytes_per_pixel register
  localparam int CFG_W   = 16;   // config write data, widest register
  localparam int START_W = 16;   // row start, saturates at data_size + 1
  localparam int POS_W   = 17;   // walk position, stays below 2**17
  localparam int X_W     = 17;   // decoded pixel count before the width check
  localparam int COBY_W  = 11;   // colour run times bytes per pixel
  localparam int PIX_W   = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ROW  = 2'd1;
  localparam logic [1:0] CMD_NEW  = 2'd2;

  localparam logic [1:0] REG_DATA_SIZE       = 2'd0;
  localparam logic [1:0] REG_SPRITE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BEYOND       = 3'd1;
  localparam logic [2:0] ST_NOT_DRAWABLE = 3'd2;
  localparam logic [2:0] ST_PAIR         = 3'd3;
  localparam logic [2:0] ST_WIDE         = 3'd4;
  localparam logic [2:0] ST_COLOURS      = 3'd5;
  localparam logic [2:0] ST_SKIPPED      = 3'd6;

  typedef enum logic [1:0] {K_LOAD, K_ROW, K_NEW} kind_t;

  typedef enum logic [1:0] {RC_WALK, RC_BEYOND, RC_NOT_DRAWABLE} row_class_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          data_byte;
    logic [START_W-1:0]  start;
    row_class_t          row_class;
    logic                last_row;
  } entry_t;

  typedef struct packed {
    logic [DS_W-1:0]   data_size;
    logic [SW_W-1:0]   sprite_width;
    logic [BPP_W-1:0]  bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [2:0]        status;
    logic [PIX_W-1:0]  decoded_pixels;
    logic              sprite_ok;
    logic              done_res;
  } result_t;

endpackage

### rtl/rssc_ram.sv
`timescale 1ns / 1ps
// rssc_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rssc_front.sv
`timescale 1ns / 1ps
// rssc_front: classifies accepted items and keeps the running row start
// depends on rssc_pkg

module rssc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      cmd,
  input  logic [7:0]                      data_byte,
  input  logic [15:0]                     row_length,
  input  logic                            last_row,
  input  logic [rssc_pkg::DS_W-1:0]       data_size,
  output logic                            push,
  output rssc_pkg::entry_t                entry
);

  logic [rssc_pkg::START_W-1:0] next_row_start;
  logic [rssc_pkg::START_W-1:0] next_row_start_next;
  logic [rssc_pkg::START_W-1:0] limit;
  logic [rssc_pkg::START_W:0]   sum;
  logic [rssc_pkg::START_W-1:0] ds_ext;

  assign ds_ext = rssc_pkg::START_W'(data_size);
  assign limit  = ds_ext + rssc_pkg::START_W'(1);
  assign sum    = {1'b0, next_row_start} + {1'b0, row_length};

  // running sum saturates one past the data end
  assign next_row_start_next = (sum > {1'b0, limit}) ? limit
                                                     : sum[rssc_pkg::START_W-1:0];

  always_comb begin
    entry.data_byte = data_byte;
    entry.start     = next_row_start;
    entry.last_row  = last_row;
    entry.kind      = rssc_pkg::K_LOAD;
    push            = 1'b0;
    if (next_row_start > ds_ext) begin
      entry.row_class = rssc_pkg::RC_BEYOND;
    end else if (next_row_start == ds_ext) begin
      entry.row_class = rssc_pkg::RC_NOT_DRAWABLE;
    end else begin
      entry.row_class = rssc_pkg::RC_WALK;
    end
    case (cmd)
      rssc_pkg::CMD_LOAD: begin
        entry.kind = rssc_pkg::K_LOAD;
        push       = accept;
      end
      rssc_pkg::CMD_ROW: begin
        entry.kind = rssc_pkg::K_ROW;
        push       = accept;
      end
      rssc_pkg::CMD_NEW: begin
        entry.kind = rssc_pkg::K_NEW;
        push       = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_row_start <= '0;
    end else if (accept && cmd == rssc_pkg::CMD_NEW) begin
      next_row_start <= '0;
    end else if (accept && cmd == rssc_pkg::CMD_ROW) begin
      next_row_start <= next_row_start_next;
    end
  end

endmodule

### rtl/rssc_fifo.sv
`timescale 1ns / 1ps
// rssc_fifo: short item queue between the front and the row walker
// depends on rssc_pkg

module rssc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rssc_pkg::entry_t  push_entry,
  input  logic              pop,
  output rssc_pkg::entry_t  head,
  output logic              empty,
  output logic              full
);

  rssc_pkg::entry_t                slots [rssc_pkg::FIFO_DEPTH];
  logic [rssc_pkg::FIFO_PW-1:0]    wr_ptr;
  logic [rssc_pkg::FIFO_PW-1:0]    rd_ptr;
  logic [rssc_pkg::FIFO_CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == rssc_pkg::FIFO_CW'(rssc_pkg::FIFO_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rssc_pkg::FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rssc_pkg::FIFO_PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + rssc_pkg::FIFO_CW'(1);
        2'b01:   count <= count - rssc_pkg::FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/rssc_back.sv
`timescale 1ns / 1ps
// rssc_back: executes queued items: stores data bytes, walks rows, keeps the verdict
// depends on rssc_pkg and rssc_ram

module rssc_back #(
  parameter int MAX_DATA_BYTES = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  rssc_pkg::cfg_t    cfg,
  input  logic              empty,
  input  rssc_pkg::entry_t  head,
  output logic              pop,
  output rssc_pkg::result_t res
);

  localparam int AW = $clog2(MAX_DATA_BYTES);
  localparam int LW = AW + 1;
  localparam int CW = (LW > rssc_pkg::POS_W) ? LW : rssc_pkg::POS_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_DATA_BYTES);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_DATA_BYTES);

  typedef enum logic [2:0] {S_IDLE, S_CNT_RD, S_CNT, S_SEG, S_TR, S_CO, S_CHK} state_t;

  state_t                          state;
  logic [LW-1:0]                   load_address;
  logic [2:0]                      first_error;
  logic [rssc_pkg::POS_W-1:0]      pos;
  logic [7:0]                      cnt;
  logic [7:0]                      tr;
  logic [rssc_pkg::X_W-1:0]        x;
  logic [rssc_pkg::COBY_W-1:0]     coby;
  logic                            last_q;
  logic                            rd_oob;

  logic [rssc_pkg::POS_W-1:0]      rd_addr;
  logic [7:0]                      ram_rdata;
  logic [7:0]                      byte_rd;
  logic                            ram_we;
  logic                            fin;
  logic [2:0]                      fin_status;
  logic [rssc_pkg::PIX_W-1:0]      fin_pixels;
  logic                            fin_last;
  logic [2:0]                      err_next;
  logic [rssc_pkg::PIX_W-1:0]      x_sat;

  assign rd_addr = (state == S_TR) ? pos + rssc_pkg::POS_W'(1) : pos;
  assign byte_rd = rd_oob ? 8'd0 : ram_rdata;
  assign ram_we  = pop && head.kind == rssc_pkg::K_LOAD && load_address < MAX_L;
  assign x_sat   = (x > rssc_pkg::X_W'(16'hFFFF)) ? 16'hFFFF : x[rssc_pkg::PIX_W-1:0];

  rssc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_address[AW-1:0]),
    .wdata (head.data_byte),
    .raddr (AW'(rd_addr)),
    .rdata (ram_rdata)
  );

  always_comb begin
    pop        = (state == S_IDLE) && !empty;
    fin        = 1'b0;
    fin_status = rssc_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (pop && head.kind == rssc_pkg::K_ROW) begin
          if (first_error != rssc_pkg::ST_OK) begin
            fin        = 1'b1;
            fin_status = rssc_pkg::ST_SKIPPED;
          end else if (head.row_class == rssc_pkg::RC_BEYOND) begin
            fin        = 1'b1;
            fin_status = rssc_pkg::ST_BEYOND;
          end else if (head.row_class == rssc_pkg::RC_NOT_DRAWABLE) begin
            fin        = 1'b1;
            fin_status = rssc_pkg::ST_NOT_DRAWABLE;
          end
        end
      end
      S_SEG: begin
        if (cnt == 8'd0) begin
          fin        = 1'b1;
          fin_status = rssc_pkg::ST_OK;
        end else if (pos + rssc_pkg::POS_W'(1) >= rssc_pkg::POS_W'(cfg.data_size)) begin
          fin        = 1'b1;
          fin_status = rssc_pkg::ST_PAIR;
        end
      end
      S_CHK: begin
        if (x > rssc_pkg::X_W'(cfg.sprite_width)) begin
          fin        = 1'b1;
          fin_status = rssc_pkg::ST_WIDE;
        end else if ((rssc_pkg::POS_W+1)'(pos) + (rssc_pkg::POS_W+1)'(coby)
                     > (rssc_pkg::POS_W+1)'(cfg.data_size)) begin
          fin        = 1'b1;
          fin_status = rssc_pkg::ST_COLOURS;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    fin_pixels = (state == S_IDLE) ? '0 : x_sat;
    fin_last   = (state == S_IDLE) ? head.last_row : last_q;
    err_next   = (fin && fin_status != rssc_pkg::ST_OK && fin_status != rssc_pkg::ST_SKIPPED)
                 ? fin_status : first_error;
  end

  always_ff @(posedge clk) begin
    rd_oob <= (CW'(rd_addr) >= MAX_C);
    if (rst) begin
      state        <= S_IDLE;
      res.valid    <= 1'b0;
      load_address <= '0;
      first_error  <= rssc_pkg::ST_OK;
    end else begin
      res.valid <= fin;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.kind)
              rssc_pkg::K_LOAD: begin
                if (load_address < MAX_L) begin
                  load_address <= load_address + LW'(1);
                end
              end
              rssc_pkg::K_NEW: begin
                load_address <= '0;
                first_error  <= rssc_pkg::ST_OK;
              end
              rssc_pkg::K_ROW: begin
                pos    <= rssc_pkg::POS_W'(head.start);
                last_q <= head.last_row;
                // skipped rows and rows rejected by the start check stay in idle
                if (!fin) begin
                  state <= S_CNT_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CNT_RD: begin
          pos   <= pos + rssc_pkg::POS_W'(1);
          state <= S_CNT;
        end
        S_CNT: begin
          cnt   <= byte_rd;
          x     <= '0;
          state <= S_SEG;
        end
        S_SEG: begin
          state <= fin ? S_IDLE : S_TR;
        end
        S_TR: begin
          tr    <= byte_rd;
          state <= S_CO;
        end
        S_CO: begin
          x     <= x + rssc_pkg::X_W'(tr) + rssc_pkg::X_W'(byte_rd);
          pos   <= pos + rssc_pkg::POS_W'(2);
          coby  <= rssc_pkg::COBY_W'(byte_rd) * rssc_pkg::COBY_W'(cfg.bytes_per_pixel);
          state <= S_CHK;
        end
        S_CHK: begin
          pos   <= pos + rssc_pkg::POS_W'(coby);
          cnt   <= cnt - 8'd1;
          state <= fin ? S_IDLE : S_SEG;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a finished row updates the verdict
      if (fin) begin
        res.status         <= fin_status;
        res.decoded_pixels <= fin_pixels;
        res.sprite_ok      <= (err_next == rssc_pkg::ST_OK);
        res.done_res       <= fin_last;
        first_error        <= err_next;
      end
    end
  end

  a_verdict_matches: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.sprite_ok == (first_error == rssc_pkg::ST_OK)))
    else $error("sprite_ok disagrees with the stored error");

  a_skip_shape: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == rssc_pkg::ST_SKIPPED) |->
      (!res.sprite_ok && res.decoded_pixels == '0))
    else $error("skipped row with pixels or a good verdict");

  a_chk_after_co: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> ($past(state) == S_CO))
    else $error("segment check entered out of order");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != rssc_pkg::ST_OK && !(pop && head.kind == rssc_pkg::K_NEW)) |=>
      (first_error == $past(first_error)))
    else $error("first error changed without a new sprite");

endmodule

### rtl/rle_sprite_scanline_checker_core.sv
`timescale 1ns / 1ps
// rle_sprite_scanline_checker_core: top level, config registers and the
// front / queue / row walker chain; depends on rssc_pkg and all rssc_* modules
//
//  channel   direction  handshake              payload
//  command   in         start, busy            cmd, data_byte, row_length, last_row
//  config    in         cfg_we                 cfg_index, cfg_data
//  result    out        result_valid           status, decoded_pixels, sprite_ok, done_res
//
// an item is taken when start is high and busy low; busy means the 4-entry queue is full
// load, new-sprite and rows rejected up front retire from the queue at one item a cycle
// while no row is being walked; a walked row is paced by the single read port of the
// data store: count byte, then transparent and colour byte per segment
// result_valid pulses for one cycle and cannot be held off; sync reset, no store clear

module rle_sprite_scanline_checker_core #(
  parameter int MAX_DATA_BYTES = 16384
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [7:0]                  data_byte,
  input  logic [15:0]                 row_length,
  input  logic                        last_row,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rssc_pkg::CFG_W-1:0]  cfg_data,
  output logic                        result_valid,
  output logic [2:0]                  status,
  output logic [15:0]                 decoded_pixels,
  output logic                        sprite_ok,
  output logic                        done_res
);

  rssc_pkg::cfg_t     cfg;
  rssc_pkg::entry_t   push_entry;
  rssc_pkg::entry_t   head;
  rssc_pkg::result_t  res;
  logic               accept;
  logic               push;
  logic               pop;
  logic               empty;
  logic               full;

  assign busy   = full;
  assign accept = start && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_size       <= '0;
      cfg.sprite_width    <= '0;
      cfg.bytes_per_pixel <= rssc_pkg::BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rssc_pkg::REG_DATA_SIZE:       cfg.data_size <= cfg_data[rssc_pkg::DS_W-1:0];
        rssc_pkg::REG_SPRITE_WIDTH:    cfg.sprite_width <= cfg_data;
        rssc_pkg::REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[rssc_pkg::BPP_W-1:0];
        default:                       cfg <= cfg;
      endcase
    end
  end

  rssc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .row_length (row_length),
    .last_row   (last_row),
    .data_size  (cfg.data_size),
    .push       (push),
    .entry      (push_entry)
  );

  rssc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  rssc_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

  assign result_valid   = res.valid;
  assign status         = res.status;
  assign decoded_pixels = res.decoded_pixels;
  assign sprite_ok      = res.sprite_ok;
  assign done_res       = res.done_res;

endmodule

### tb/rle_sprite_scanline_checker_core_tb.sv
`timescale 1ns / 1ps
// rle_sprite_scanline_checker_core_tb: self-checking bench for the sprite scanline checker
// depends on rssc_pkg and rle_sprite_scanline_checker_core; keeps a shadow store and
// verdict queue, sends load / row / new-sprite items and checks every row verdict

module rle_sprite_scanline_checker_core_tb;

  localparam int STORE_DEPTH  = 512;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int IDLE_TAIL    = 32;
  localparam int RANDOM_ITEMS = 300;
  localparam int MIN_ROWS     = 8;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] pixels;
    logic        ok;
    logic        done;
  } row_verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic [15:0] row_length;
  logic        last_row;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [rssc_pkg::CFG_W-1:0] cfg_data;
  logic        result_valid;
  logic [2:0]  status;
  logic [15:0] decoded_pixels;
  logic        sprite_ok;
  logic        done_res;

  // shadow copy of the block state
  logic [7:0]  shadow_store [STORE_DEPTH];
  int unsigned shadow_load_addr = 0;
  int unsigned shadow_row_start = 0;
  logic [2:0]  shadow_err = rssc_pkg::ST_OK;
  int unsigned reg_data_size = 0;
  int unsigned reg_sprite_width = 0;
  int unsigned reg_bpp = 1;

  row_verdict_t pending_verdicts[$];
  row_verdict_t got_verdict;
  logic [7:0]   sprite_body[$];
  int           row_lens[$];
  int           max_gap = 8;
  int           fail_count = 0;
  int           cycle_count = 0;

  rle_sprite_scanline_checker_core #(
    .MAX_DATA_BYTES(STORE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .data_byte(data_byte),
    .row_length(row_length),
    .last_row(last_row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .status(status),
    .decoded_pixels(decoded_pixels),
    .sprite_ok(sprite_ok),
    .done_res(done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned store_byte(input int unsigned addr);
    if (addr >= STORE_DEPTH) return 0;
    return shadow_store[addr];
  endfunction

  // start check, then segment walk; updates the running row start and sticky error
  function automatic row_verdict_t walk_scanline(input logic [15:0] len, input logic lr);
    row_verdict_t v;
    int unsigned row_start, sum, pos, count, x, tr, co, seg;
    logic [2:0] st;
    row_start = shadow_row_start;
    sum = row_start + len;
    shadow_row_start = (sum > reg_data_size + 1) ? reg_data_size + 1 : sum;
    x = 0;
    if (shadow_err != rssc_pkg::ST_OK) begin
      st = rssc_pkg::ST_SKIPPED;
    end else if (row_start > reg_data_size) begin
      st = rssc_pkg::ST_BEYOND;
    end else if (row_start == reg_data_size) begin
      st = rssc_pkg::ST_NOT_DRAWABLE;
    end else begin
      st = rssc_pkg::ST_OK;
      pos = row_start;
      count = store_byte(pos);
      pos++;
      seg = 0;
      while (st == rssc_pkg::ST_OK && seg < count) begin
        if (pos + 1 >= reg_data_size) begin
          st = rssc_pkg::ST_PAIR;
        end else begin
          tr = store_byte(pos);
          co = store_byte(pos + 1);
          pos += 2;
          x += tr + co;
          if (x > reg_sprite_width) st = rssc_pkg::ST_WIDE;
          else if (pos + co * reg_bpp > reg_data_size) st = rssc_pkg::ST_COLOURS;
          else pos += co * reg_bpp;
        end
        seg++;
      end
    end
    if (st != rssc_pkg::ST_OK && st != rssc_pkg::ST_SKIPPED) shadow_err = st;
    v.status = st;
    v.pixels = (x > 65535) ? 16'hFFFF : x[15:0];
    v.ok = (shadow_err == rssc_pkg::ST_OK);
    v.done = lr;
    return v;
  endfunction

  function automatic void absorb_command(input logic [1:0] c, input logic [7:0] b,
                                         input logic [15:0] len, input logic lr);
    case (c)
      rssc_pkg::CMD_LOAD: begin
        if (shadow_load_addr < STORE_DEPTH) begin
          shadow_store[shadow_load_addr] = b;
          shadow_load_addr++;
        end
      end
      rssc_pkg::CMD_ROW: pending_verdicts.push_back(walk_scanline(len, lr));
      rssc_pkg::CMD_NEW: begin
        shadow_load_addr = 0;
        shadow_row_start = 0;
        shadow_err = rssc_pkg::ST_OK;
      end
      default: ;
    endcase
  endfunction

  // appends one well-formed row to sprite_body, returns its pixel count
  function automatic int add_row(input int nseg, input int bpp, input int max_co);
    int s, k, tr, co, first, px;
    logic [31:0] v;
    first = sprite_body.size();
    px = 0;
    v = nseg;
    sprite_body.push_back(v[7:0]);
    for (s = 0; s < nseg; s++) begin
      tr = $urandom_range(0, 255);
      co = $urandom_range(0, max_co);
      v = tr;
      sprite_body.push_back(v[7:0]);
      v = co;
      sprite_body.push_back(v[7:0]);
      px += tr + co;
      for (k = 0; k < co * bpp; k++) begin
        v = $urandom();
        sprite_body.push_back(v[7:0]);
      end
    end
    row_lens.push_back(sprite_body.size() - first);
    return px;
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [7:0] b,
                           input logic [15:0] len, input logic lr);
    int gap;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    data_byte <= b;
    row_length <= len;
    last_row <= lr;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_command(c, b, len, lr);
  endtask

  task automatic send_load(input logic [7:0] b);
    send_item(rssc_pkg::CMD_LOAD, b, 16'($urandom()), 1'($urandom()));
  endtask

  task automatic send_row(input logic [15:0] len, input logic lr);
    send_item(rssc_pkg::CMD_ROW, 8'($urandom()), len, lr);
  endtask

  task automatic send_new();
    send_item(rssc_pkg::CMD_NEW, 8'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  task automatic send_spare();
    send_item(CMD_SPARE, 8'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  task automatic load_body();
    foreach (sprite_body[i]) send_load(sprite_body[i]);
  endtask

  // load and new-sprite items leave no verdict, so give the queue time to retire them
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic program_regs(input int ds, input int sw, input int bpp);
    logic [31:0] junk, dsv, swv, bppv;
    junk = $urandom();
    dsv = ds;
    swv = sw;
    bppv = bpp;
    cfg_we <= 1'b1;
    cfg_index <= rssc_pkg::REG_DATA_SIZE;
    cfg_data <= {junk[15], dsv[14:0]};
    @(posedge clk);
    reg_data_size = dsv[14:0];
    cfg_index <= rssc_pkg::REG_SPRITE_WIDTH;
    cfg_data <= swv[15:0];
    @(posedge clk);
    reg_sprite_width = swv[15:0];
    cfg_index <= rssc_pkg::REG_BYTES_PER_PIXEL;
    cfg_data <= {junk[12:0], bppv[2:0]};
    @(posedge clk);
    reg_bpp = bppv[2:0];
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input int ds, input int sw, input int bpp);
    wait_idle();
    program_regs(ds, sw, bpp);
    send_new();
  endtask

  // fills the whole store, overruns it, then reads past its end
  task automatic test_store_fill();
    int a, px;
    logic [31:0] v;
    sprite_body.delete();
    row_lens.delete();
    px = add_row(120, 1, 1);
    repeat (3) px = add_row($urandom_range(0, 4), 1, 6);
    reconfigure(STORE_DEPTH, 65535, 1);
    for (a = 0; a < STORE_DEPTH; a++) begin
      v = $urandom();
      if (a < sprite_body.size()) v = sprite_body[a];
      else if (a == STORE_DEPTH - 1) v = 3;
      send_load(v[7:0]);
    end
    // dropped: a wrap to address 0 would corrupt the first count byte
    repeat (3) send_load(8'd0);
    foreach (row_lens[i]) send_row(16'(row_lens[i]), 1'b0);
    send_row(5, 1'b0);
    send_row(16'($urandom_range(0, 40)), 1'b1);
    reconfigure(32767, 65535, 1);
    send_row(16'(STORE_DEPTH - 1), 1'b0);
    send_row(100, 1'b0);
    send_row(16'hFFFF, 1'b0);
    send_row(0, 1'b1);
    send_row(1, 1'b1);
  endtask

  task automatic test_start_checks();
    sprite_body = {8'd1, 8'd2, 8'd3, 8'hAA, 8'h55, 8'hFF};
    reconfigure(6, 5, 1);
    load_body();
    send_row(6, 1'b0);
    send_row(0, 1'b0);
    send_row(3, 1'b1);
    send_new();
    send_row(7, 1'b0);
    send_row(1, 1'b1);
    // zero-segment row against a zero width
    sprite_body = {8'd0};
    reconfigure(1, 0, 1);
    load_body();
    send_row(1, 1'b1);
    reconfigure(0, 0, 1);
    send_row(0, 1'b1);
  endtask

  task automatic test_walk_errors();
    sprite_body = {8'd2, 8'd1, 8'd1, 8'h12, 8'h34, 8'd3, 8'd0};
    reconfigure(7, 5, 2);
    load_body();
    send_row(7, 1'b1);
    reconfigure(6, 5, 2);
    send_row(7, 1'b1);
    reconfigure(7, 4, 2);
    send_row(7, 1'b1);
    sprite_body = {8'd1, 8'd0, 8'd3, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'h81, 8'h7E};
    reconfigure(9, 3, 2);
    load_body();
    send_row(9, 1'b1);
    reconfigure(8, 3, 2);
    send_row(9, 1'b1);
  endtask

  task automatic test_wide_pixels();
    logic [31:0] v;
    // no colour bytes per pixel: long runs push the count past 16 bits
    sprite_body.delete();
    sprite_body.push_back(8'd130);
    repeat (130) begin
      sprite_body.push_back(8'd255);
      sprite_body.push_back(8'd255);
    end
    reconfigure(261, 65535, 0);
    load_body();
    send_row(261, 1'b1);
    sprite_body = {8'd1, 8'd4, 8'd2};
    repeat (14) begin
      v = $urandom();
      sprite_body.push_back(v[7:0]);
    end
    reconfigure(17, 65535, 7);
    load_body();
    send_row(17, 1'b0);
    reconfigure(16, 65535, 7);
    send_row(17, 1'b1);
    send_row(0, 1'b0);
  endtask

  task automatic test_ignored_and_restart();
    sprite_body = {8'd1, 8'd2, 8'd3, 8'hAA, 8'h55, 8'hFF};
    reconfigure(6, 5, 1);
    max_gap = 0;
    load_body();
    send_spare();
    send_spare();
    send_row(6, 1'b1);
    send_spare();
    send_row(0, 1'b0);
    send_row(6, 1'b0);
    send_new();
    send_row(6, 1'b1);
    max_gap = 8;
  endtask

  task automatic test_random_sprites();
    int sent, rows_sent, nrows, r, bpp, ds, sw, widest, px, len, kind;
    bit reprogram;
    logic lr;
    sent = 0;
    rows_sent = 0;
    while (sent < RANDOM_ITEMS || rows_sent < MIN_ROWS) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      reprogram = (sent == 0) || ($urandom_range(0, 1) == 0);
      if (!reprogram) bpp = reg_bpp;
      else begin
        kind = $urandom_range(0, 9);
        bpp = (kind == 0) ? 0 : (kind == 1) ? 7 : $urandom_range(1, 4);
      end
      sprite_body.delete();
      row_lens.delete();
      widest = 0;
      nrows = $urandom_range(1, 6);
      for (r = 0; r < nrows; r++) begin
        kind = $urandom_range(0, 39);
        if (kind == 0) px = add_row($urandom_range(6, 255), bpp, 1);
        else if (kind < 3) px = add_row(1, bpp, 255);
        else px = add_row($urandom_range(0, 3), bpp, 3);
        if (px > widest) widest = px;
      end
      if (reprogram) begin
        kind = $urandom_range(0, 7);
        if (kind < 4) ds = sprite_body.size();
        else if (kind == 4) ds = sprite_body.size() - $urandom_range(1, 8);
        else if (kind == 5) ds = $urandom_range(0, STORE_DEPTH);
        else if (kind == 6) ds = sprite_body.size() + $urandom_range(1, 8);
        else ds = $urandom_range(0, 1) ? STORE_DEPTH : 0;
        if (ds < 0) ds = 0;
        kind = $urandom_range(0, 7);
        if (kind < 4) sw = widest + $urandom_range(0, 3);
        else if (kind == 4) sw = (widest > 0) ? widest - 1 : 0;
        else if (kind == 5) sw = $urandom_range(0, 65535);
        else if (kind == 6) sw = 65535;
        else sw = 0;
        if (sw > 65535) sw = 65535;
        wait_idle();
        program_regs(ds, sw, bpp);
      end
      // occasionally run on from the previous sprite without a restart
      if ($urandom_range(0, 9) != 0) begin
        send_new();
        sent++;
      end
      load_body();
      sent += sprite_body.size();
      for (r = 0; r < nrows; r++) begin
        if ($urandom_range(0, 19) == 0) send_spare();
        if ($urandom_range(0, 29) == 0) begin
          send_load(8'($urandom()));
          sent++;
        end
        len = row_lens[r];
        kind = $urandom_range(0, 23);
        if (kind == 0) len = $urandom_range(0, 65535);
        else if (kind == 1) len = len + 1;
        else if (kind == 2 && len > 0) len = len - 1;
        lr = (r == nrows - 1) || ($urandom_range(0, 15) == 0);
        send_row(16'(len), lr);
        sent++;
        rows_sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_row(16'($urandom()), 1'($urandom()));
        sent++;
        rows_sent++;
      end
    end
  endtask

  // verdicts are sampled mid-cycle, away from the edges where items are taken
  always @(negedge clk) begin
    if (!rst && result_valid !== 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no row pending: status %0d pixels %0d", status, decoded_pixels);
        fail_count++;
      end else begin
        got_verdict = pending_verdicts.pop_front();
        if (status !== got_verdict.status) begin
          $error("status: expected %0d, actual %0d", got_verdict.status, status);
          fail_count++;
        end
        if (decoded_pixels !== got_verdict.pixels) begin
          $error("decoded_pixels: expected %0d, actual %0d", got_verdict.pixels,
                 decoded_pixels);
          fail_count++;
        end
        if (sprite_ok !== got_verdict.ok) begin
          $error("sprite_ok: expected %0b, actual %0b", got_verdict.ok, sprite_ok);
          fail_count++;
        end
        if (done_res !== got_verdict.done) begin
          $error("done_res: expected %0b, actual %0b", got_verdict.done, done_res);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= rssc_pkg::CMD_LOAD;
    data_byte <= 8'd0;
    row_length <= 16'd0;
    last_row <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rssc_pkg::REG_DATA_SIZE;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_store_fill();
    test_start_checks();
    test_walk_errors();
    test_wide_pixels();
    test_ignored_and_restart();
    test_random_sprites();
    wait_idle();
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rssc_pkg.sv
rtl/rssc_ram.sv
rtl/rssc_front.sv
rtl/rssc_fifo.sv
rtl/rssc_back.sv
rtl/rle_sprite_scanline_checker_core.sv
tb/rle_sprite_scanline_checker_core_tb.sv
